// File: rtl/exp_mixture_jump_sampler_macros.svh
// ----------------------------------------------------------------------------
// exp_mixture_jump_sampler assertion macros
// shared property shorthands on clock / reset of the including module
// ----------------------------------------------------------------------------
`ifndef EXP_MIXTURE_JUMP_SAMPLER_MACROS_SVH
`define EXP_MIXTURE_JUMP_SAMPLER_MACROS_SVH

// same-cycle implication
`define EMJS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EMJS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/emjs_pkg.sv
// ----------------------------------------------------------------------------
// emjs_pkg
// shared codes, widths and divider interface types for the jump sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package emjs_pkg;

   // action codes carried in the request tuser
   localparam logic [2:0] ACT_WR_BREAK = 3'd0;
   localparam logic [2:0] ACT_WR_COMP  = 3'd1;
   localparam logic [2:0] ACT_SAMPLE   = 3'd2;
   localparam logic [2:0] ACT_LAPLACE  = 3'd3;
   localparam logic [2:0] ACT_SCALE    = 3'd4;

   // error codes carried in the response tuser
   localparam logic [1:0] ERR_OK           = 2'd0;
   localparam logic [1:0] ERR_ZERO_TOTAL   = 2'd1;
   localparam logic [1:0] ERR_ZERO_UNIFORM = 2'd2;

   // register indexes (word address bit 2)
   localparam logic REG_PIECES     = 1'b0;
   localparam logic REG_COMPONENTS = 1'b1;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
   localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;

   localparam int REQ_DATA_W = 216;
   localparam int RSP_DATA_W = 72;
   localparam int TOT_W      = 20;
   localparam int NUM_W      = 52;

   // serial divider: remainder stays below the 65-bit divisor
   localparam int DIV_W = 65;
   localparam int QUO_W = 32;
   localparam int CNT_W = 5;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] divisor;
      logic [DIV_W-1:0] rem_init;
      logic [QUO_W-1:0] dividend_lo;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/emjs_serial_div.sv
// ----------------------------------------------------------------------------
// emjs_serial_div
// restoring divider, one quotient bit per cycle, 32 bits per run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emjs_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  emjs_pkg::div_req_type div_req,
   output emjs_pkg::div_rsp_type div_rsp
);
   import emjs_pkg::*;

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0] lo_ff, lo_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   reduced;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, lo_ff[QUO_W-1]};
      reduced = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      lo_in   = lo_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.rem_init;
         dvs_in  = div_req.divisor;
         lo_in   = div_req.dividend_lo;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? reduced[DIV_W-1:0] : shifted[DIV_W-1:0];
         lo_in  = {lo_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUO_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: rtl/exp_mixture_jump_sampler.sv
// ----------------------------------------------------------------------------
// exp_mixture_jump_sampler
// piecewise hyperexponential mixture: table loads, inverse-transform jump
// sampling, mixture laplace transform and mean scaling
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser action, tdata item fields
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser error, tdata result fields
//  csr     | in        | apb psel/penable      | pieces_in_use, components_in_use
//
//  one transaction in flight; writes pass one write state, unused actions go straight to the response
//  sample: a breakpoint scan, a total and a pick pass over the components,
//   up to 31 normalize shifts and 32 log squaring rounds (shared 32x32 multiplier)
//  laplace: a total pass, then per component a multiply, serial divide and
//   weighted add, then a final divide; scale: read, multiply, write per component
//  after reset all MAX_PIECES*MAX_COMPONENTS mean/weight table entries are
//   cleared with req_tready low
//  a finished result sits in the output register; a new request is taken
//   meanwhile and its result waits for the register to drain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "exp_mixture_jump_sampler_macros.svh"

module exp_mixture_jump_sampler #(
   parameter int MAX_PIECES     = 16,
   parameter int MAX_COMPONENTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // interval[3:0], component[6:4], time_value[38:7], mean_value[70:39],
   // weight_value[86:71], uniform_select[118:87], uniform_size[150:119],
   // laplace_arg[182:151], scale_factor[214:183], zero pad[215]
   input  logic [emjs_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[2:0]
   input  logic [2:0]                      req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // jump_size[31:0], chosen_interval[35:32], chosen_component[38:36],
   // laplace_value[70:39], zero pad[71]
   output logic [emjs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // error[1:0]
   output logic [1:0]                      rsp_tuser,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import emjs_pkg::*;

   localparam int PW    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int DEPTH = MAX_PIECES * MAX_COMPONENTS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_WRITE    = 5'd2;
   localparam logic [4:0] S_BP_RD    = 5'd3;
   localparam logic [4:0] S_BP_EV    = 5'd4;
   localparam logic [4:0] S_TOT_RD   = 5'd5;
   localparam logic [4:0] S_TOT_EV   = 5'd6;
   localparam logic [4:0] S_TGT_MUL  = 5'd7;
   localparam logic [4:0] S_TGT_EV   = 5'd8;
   localparam logic [4:0] S_PICK_RD  = 5'd9;
   localparam logic [4:0] S_PICK_EV  = 5'd10;
   localparam logic [4:0] S_NORM     = 5'd11;
   localparam logic [4:0] S_SQ_MUL   = 5'd12;
   localparam logic [4:0] S_SQ_UPD   = 5'd13;
   localparam logic [4:0] S_LN_HI    = 5'd14;
   localparam logic [4:0] S_LN_LO    = 5'd15;
   localparam logic [4:0] S_LN_SUM   = 5'd16;
   localparam logic [4:0] S_JMP_HI   = 5'd17;
   localparam logic [4:0] S_JMP_LO   = 5'd18;
   localparam logic [4:0] S_JMP_SUM  = 5'd19;
   localparam logic [4:0] S_LAP_RD   = 5'd20;
   localparam logic [4:0] S_LAP_MUL  = 5'd21;
   localparam logic [4:0] S_LAP_DIV  = 5'd22;
   localparam logic [4:0] S_LAP_DIVW = 5'd23;
   localparam logic [4:0] S_LAP_ACC  = 5'd24;
   localparam logic [4:0] S_LAP_ADD  = 5'd25;
   localparam logic [4:0] S_FIN_DIV  = 5'd26;
   localparam logic [4:0] S_FIN_DIVW = 5'd27;
   localparam logic [4:0] S_SCL_RD   = 5'd28;
   localparam logic [4:0] S_SCL_MUL  = 5'd29;
   localparam logic [4:0] S_SCL_WR   = 5'd30;
   localparam logic [4:0] S_RESP     = 5'd31;

   // flat table address of (interval, component)
   function automatic logic [AW-1:0] tab_addr(input logic [PW-1:0] row,
                                              input logic [3:0] comp);
      tab_addr = AW'(row) * AW'(MAX_COMPONENTS) + AW'(comp);
   endfunction

   // control state
   logic [4:0]    state_ff, state_in;
   logic [4:0]    pieces_ff;
   logic [3:0]    comps_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // item fields
   logic [2:0]  act_ff, act_in;
   logic [3:0]  iv_ff, iv_in;
   logic [2:0]  comp_ff, comp_in;
   logic [31:0] tval_ff, tval_in;
   logic [31:0] mval_ff, mval_in;
   logic [15:0] wval_ff, wval_in;
   logic [31:0] usel_ff, usel_in;
   logic [31:0] usz_ff, usz_in;
   logic [31:0] xarg_ff, xarg_in;
   logic [31:0] scl_ff, scl_in;

   // working registers
   logic [PW-1:0]    row_ff, row_in;
   logic [4:0]       sk_ff, sk_in;
   logic [3:0]       ck_ff, ck_in;
   logic [TOT_W-1:0] tot_ff, tot_in;
   logic [TOT_W-1:0] run_ff, run_in;
   logic [TOT_W:0]   tgt_ff, tgt_in;
   logic [31:0]      m_ff, m_in;
   logic [4:0]       sh_ff, sh_in;
   logic [31:0]      f_ff, f_in;
   logic [4:0]       rnd_ff, rnd_in;
   logic [63:0]      acc_ff, acc_in;
   logic [37:0]      e_ff, e_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [63:0]      prod_ff, prod_in;

   // result being built, and the output register
   logic [31:0]           o_jump_ff, o_jump_in;
   logic [3:0]            o_iv_ff, o_iv_in;
   logic [2:0]            o_comp_ff, o_comp_in;
   logic [31:0]           o_lap_ff, o_lap_in;
   logic [1:0]            o_err_ff, o_err_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   // tables
   logic [31:0] mean_mem [DEPTH];
   logic [15:0] wt_mem [DEPTH];
   logic [31:0] bp_mem [MAX_PIECES];
   logic [31:0] mean_rd_ff;
   logic [15:0] wt_rd_ff;
   logic [31:0] bp_rd_ff;

   logic          mean_we, wt_we, bp_we;
   logic [31:0]   mean_wdata;
   logic [15:0]   wt_wdata;
   logic [AW-1:0] raddr, waddr;

   // helpers
   logic [4:0]       pused;
   logic [3:0]       cused;
   logic             accept;
   logic             req_iv_ok, iv_ok, comp_ok;
   logic [PW-1:0]    lap_row;
   logic [TOT_W-1:0] tot_sum, run_sum;
   logic [37:0]      l_val;
   logic [64:0]      jump_sum;
   logic [47:0]      scaled;
   logic [31:0]      mul_a, mul_b;
   logic             mul_en;
   logic             last_comp;

   div_req_type div_req;
   div_rsp_type div_rsp;

   emjs_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // register clamps: zero acts as one, above the table size acts as the size
   always_comb begin
      if (pieces_ff == '0) begin
         pused = 5'd1;
      end else if (32'(pieces_ff) > MAX_PIECES) begin
         pused = 5'(MAX_PIECES);
      end else begin
         pused = pieces_ff;
      end
      if (comps_ff == '0) begin
         cused = 4'd1;
      end else if (32'(comps_ff) > MAX_COMPONENTS) begin
         cused = 4'(MAX_COMPONENTS);
      end else begin
         cused = comps_ff;
      end
   end

   assign accept    = req_tvalid && req_tready;
   assign req_iv_ok = (32'(req_tdata[3:0]) < MAX_PIECES);
   assign iv_ok     = (32'(iv_ff) < MAX_PIECES);
   assign comp_ok   = (32'(comp_ff) < MAX_COMPONENTS);
   assign lap_row   = req_iv_ok ? PW'(req_tdata[3:0]) : PW'(MAX_PIECES - 1);
   assign last_comp = (ck_ff == cused - 4'd1);
   assign tot_sum   = tot_ff + TOT_W'(wt_rd_ff);
   assign run_sum   = run_ff + TOT_W'(wt_rd_ff);
   // log2 of 1/u as (32-p) minus the squaring fraction, p = 31 - shifts
   assign l_val     = {6'(sh_ff) + 6'd1, 32'b0} - {6'b0, f_ff};
   assign jump_sum  = {1'b0, acc_ff} + 65'(prod_ff[63:32]);
   assign scaled    = prod_ff[63:16];

   // shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_TGT_MUL: begin
            mul_a = usel_ff;
            mul_b = 32'(tot_ff);
         end
         S_SQ_MUL: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         S_LN_HI: begin
            mul_a = 32'(l_val[37:32]);
            mul_b = LN2_Q32;
         end
         S_LN_LO: begin
            mul_a = l_val[31:0];
            mul_b = LN2_Q32;
         end
         S_JMP_HI: begin
            mul_a = mean_rd_ff;
            mul_b = 32'(e_ff[37:32]);
         end
         S_JMP_LO: begin
            mul_a = mean_rd_ff;
            mul_b = e_ff[31:0];
         end
         S_LAP_MUL: begin
            mul_a = mean_rd_ff;
            mul_b = xarg_ff;
         end
         S_LAP_ACC: begin
            mul_a = 32'(wt_rd_ff);
            mul_b = div_rsp.quotient;
         end
         S_SCL_MUL: begin
            mul_a = mean_rd_ff;
            mul_b = scl_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
      prod_in = mul_en ? ({32'b0, mul_a} * {32'b0, mul_b}) : prod_ff;
   end

   // divider launch
   always_comb begin
      div_req.start       = 1'b0;
      div_req.divisor     = '0;
      div_req.rem_init    = '0;
      div_req.dividend_lo = '0;
      case (state_ff)
         S_LAP_DIV: begin
            // 2^63 / (2^32 + mean*x): the upper dividend word is 2^31
            div_req.start    = 1'b1;
            div_req.divisor  = DIV_W'(prod_ff) + (DIV_W'(1) << 32);
            div_req.rem_init = DIV_W'(1) << 31;
         end
         S_FIN_DIV: begin
            div_req.start       = 1'b1;
            div_req.divisor     = DIV_W'(tot_ff);
            div_req.rem_init    = DIV_W'(num_ff[NUM_W-1:32]);
            div_req.dividend_lo = num_ff[31:0];
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   // table write port
   always_comb begin
      raddr      = tab_addr(row_ff, ck_ff);
      waddr      = (state_ff == S_CLEAR) ? clr_ff : raddr;
      mean_we    = 1'b0;
      wt_we      = 1'b0;
      bp_we      = 1'b0;
      mean_wdata = ONE_Q16;
      wt_wdata   = '0;
      case (state_ff)
         S_CLEAR: begin
            mean_we = 1'b1;
            wt_we   = 1'b1;
         end
         S_WRITE: begin
            bp_we      = (act_ff == ACT_WR_BREAK) && iv_ok;
            mean_we    = (act_ff == ACT_WR_COMP) && iv_ok && comp_ok;
            wt_we      = mean_we;
            mean_wdata = mval_ff;
            wt_wdata   = wval_ff;
         end
         S_SCL_WR: begin
            mean_we    = 1'b1;
            mean_wdata = (|scaled[47:32]) ? MAX32 : scaled[31:0];
         end
         default: begin
            mean_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mean_we) begin
         mean_mem[waddr] <= mean_wdata;
      end
      if (wt_we) begin
         wt_mem[waddr] <= wt_wdata;
      end
      if (bp_we) begin
         bp_mem[PW'(iv_ff)] <= tval_ff;
      end
      mean_rd_ff <= mean_mem[raddr];
      wt_rd_ff   <= wt_mem[raddr];
      bp_rd_ff   <= bp_mem[PW'(sk_ff)];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      act_in  = act_ff;
      iv_in   = iv_ff;
      comp_in = comp_ff;
      tval_in = tval_ff;
      mval_in = mval_ff;
      wval_in = wval_ff;
      usel_in = usel_ff;
      usz_in  = usz_ff;
      xarg_in = xarg_ff;
      scl_in  = scl_ff;
      row_in  = row_ff;
      sk_in   = sk_ff;
      ck_in   = ck_ff;
      tot_in  = tot_ff;
      run_in  = run_ff;
      tgt_in  = tgt_ff;
      m_in    = m_ff;
      sh_in   = sh_ff;
      f_in    = f_ff;
      rnd_in  = rnd_ff;
      acc_in  = acc_ff;
      e_in    = e_ff;
      num_in  = num_ff;
      o_jump_in = o_jump_ff;
      o_iv_in   = o_iv_ff;
      o_comp_in = o_comp_ff;
      o_lap_in  = o_lap_ff;
      o_err_in  = o_err_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               act_in  = req_tuser;
               iv_in   = req_tdata[3:0];
               comp_in = req_tdata[6:4];
               tval_in = req_tdata[38:7];
               mval_in = req_tdata[70:39];
               wval_in = req_tdata[86:71];
               usel_in = req_tdata[118:87];
               usz_in  = req_tdata[150:119];
               xarg_in = req_tdata[182:151];
               scl_in  = req_tdata[214:183];
               o_jump_in = '0;
               o_iv_in   = '0;
               o_comp_in = '0;
               o_lap_in  = '0;
               o_err_in  = ERR_OK;
               row_in    = PW'(req_tdata[3:0]);
               ck_in     = 4'(req_tdata[6:4]);
               case (req_tuser)
                  ACT_WR_BREAK, ACT_WR_COMP: begin
                     state_in = S_WRITE;
                  end
                  ACT_SAMPLE: begin
                     sk_in    = '0;
                     state_in = S_BP_RD;
                  end
                  ACT_LAPLACE: begin
                     row_in   = lap_row;
                     o_iv_in  = 4'(lap_row);
                     ck_in    = '0;
                     tot_in   = '0;
                     state_in = S_TOT_RD;
                  end
                  ACT_SCALE: begin
                     ck_in    = '0;
                     state_in = req_iv_ok ? S_SCL_RD : S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_WRITE: begin
            state_in = S_RESP;
         end

         // first breakpoint at or above the jump time, else the last piece
         S_BP_RD: begin
            state_in = S_BP_EV;
         end
         S_BP_EV: begin
            if (bp_rd_ff >= tval_ff || sk_ff == pused - 5'd1) begin
               row_in   = PW'(sk_ff);
               o_iv_in  = 4'(sk_ff);
               ck_in    = '0;
               tot_in   = '0;
               state_in = S_TOT_RD;
            end else begin
               sk_in    = sk_ff + 5'd1;
               state_in = S_BP_RD;
            end
         end

         // total weight of the interval
         S_TOT_RD: begin
            state_in = S_TOT_EV;
         end
         S_TOT_EV: begin
            tot_in = tot_sum;
            if (last_comp) begin
               ck_in = '0;
               if (tot_sum == '0) begin
                  o_err_in = ERR_ZERO_TOTAL;
                  state_in = S_RESP;
               end else if (act_ff == ACT_SAMPLE) begin
                  state_in = S_TGT_MUL;
               end else begin
                  num_in   = '0;
                  state_in = S_LAP_RD;
               end
            end else begin
               ck_in    = ck_ff + 4'd1;
               state_in = S_TOT_RD;
            end
         end

         // component pick: u*T <= run*2^32 becomes ceil(u*T / 2^32) <= run
         S_TGT_MUL: begin
            state_in = S_TGT_EV;
         end
         S_TGT_EV: begin
            tgt_in   = (TOT_W+1)'(prod_ff[52:32]) + (TOT_W+1)'(|prod_ff[31:0]);
            run_in   = '0;
            state_in = S_PICK_RD;
         end
         S_PICK_RD: begin
            state_in = S_PICK_EV;
         end
         S_PICK_EV: begin
            run_in = run_sum;
            if (tgt_ff <= {1'b0, run_sum} || last_comp) begin
               o_comp_in = 3'(ck_ff);
               if (usz_ff == '0) begin
                  o_jump_in = MAX32;
                  o_err_in  = ERR_ZERO_UNIFORM;
                  state_in  = S_RESP;
               end else begin
                  m_in     = usz_ff;
                  sh_in    = '0;
                  state_in = S_NORM;
               end
            end else begin
               ck_in    = ck_ff + 4'd1;
               state_in = S_PICK_RD;
            end
         end

         // normalize the uniform one bit per cycle
         S_NORM: begin
            if (m_ff[31]) begin
               rnd_in   = '0;
               f_in     = '0;
               state_in = S_SQ_MUL;
            end else begin
               m_in  = {m_ff[30:0], 1'b0};
               sh_in = sh_ff + 5'd1;
            end
         end

         // repeated squaring yields one log2 fraction bit per round
         S_SQ_MUL: begin
            state_in = S_SQ_UPD;
         end
         S_SQ_UPD: begin
            f_in   = {f_ff[30:0], prod_ff[63]};
            m_in   = prod_ff[63] ? prod_ff[63:32] : prod_ff[62:31];
            rnd_in = rnd_ff + 5'd1;
            state_in = (rnd_ff == 5'd31) ? S_LN_HI : S_SQ_MUL;
         end

         // scale log2 to natural log
         S_LN_HI: begin
            state_in = S_LN_LO;
         end
         S_LN_LO: begin
            acc_in   = prod_ff;
            state_in = S_LN_SUM;
         end
         S_LN_SUM: begin
            e_in     = acc_ff[37:0] + 38'(prod_ff[63:32]);
            state_in = S_JMP_HI;
         end

         // jump = mean * E, saturating
         S_JMP_HI: begin
            state_in = S_JMP_LO;
         end
         S_JMP_LO: begin
            acc_in   = prod_ff;
            state_in = S_JMP_SUM;
         end
         S_JMP_SUM: begin
            o_jump_in = (|jump_sum[64:32]) ? MAX32 : jump_sum[31:0];
            state_in  = S_RESP;
         end

         // laplace: sum of w_k * floor(2^63 / (2^32 + mean_k*x)), then / T
         S_LAP_RD: begin
            state_in = S_LAP_MUL;
         end
         S_LAP_MUL: begin
            state_in = S_LAP_DIV;
         end
         S_LAP_DIV: begin
            state_in = S_LAP_DIVW;
         end
         S_LAP_DIVW: begin
            if (div_rsp.done) begin
               state_in = S_LAP_ACC;
            end
         end
         S_LAP_ACC: begin
            state_in = S_LAP_ADD;
         end
         S_LAP_ADD: begin
            num_in = num_ff + prod_ff[NUM_W-1:0];
            if (last_comp) begin
               state_in = S_FIN_DIV;
            end else begin
               ck_in    = ck_ff + 4'd1;
               state_in = S_LAP_RD;
            end
         end
         S_FIN_DIV: begin
            state_in = S_FIN_DIVW;
         end
         S_FIN_DIVW: begin
            if (div_rsp.done) begin
               o_lap_in = div_rsp.quotient;
               state_in = S_RESP;
            end
         end

         // scale each in-use mean of the interval
         S_SCL_RD: begin
            state_in = S_SCL_MUL;
         end
         S_SCL_MUL: begin
            state_in = S_SCL_WR;
         end
         S_SCL_WR: begin
            if (last_comp) begin
               state_in = S_RESP;
            end else begin
               ck_in    = ck_ff + 4'd1;
               state_in = S_SCL_RD;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, o_lap_ff, o_comp_ff, o_iv_ff, o_jump_ff};
               rsp_user_in  = o_err_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pieces_ff    <= 5'd1;
         comps_ff     <= 4'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_PIECES) begin
               pieces_ff <= csr_pwdata[4:0];
            end else begin
               comps_ff <= csr_pwdata[3:0];
            end
         end
      end
      act_ff  <= act_in;
      iv_ff   <= iv_in;
      comp_ff <= comp_in;
      tval_ff <= tval_in;
      mval_ff <= mval_in;
      wval_ff <= wval_in;
      usel_ff <= usel_in;
      usz_ff  <= usz_in;
      xarg_ff <= xarg_in;
      scl_ff  <= scl_in;
      row_ff  <= row_in;
      sk_ff   <= sk_in;
      ck_ff   <= ck_in;
      tot_ff  <= tot_in;
      run_ff  <= run_in;
      tgt_ff  <= tgt_in;
      m_ff    <= m_in;
      sh_ff   <= sh_in;
      f_ff    <= f_in;
      rnd_ff  <= rnd_in;
      acc_ff  <= acc_in;
      e_ff    <= e_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
      o_jump_ff   <= o_jump_in;
      o_iv_ff     <= o_iv_in;
      o_comp_ff   <= o_comp_in;
      o_lap_ff    <= o_lap_in;
      o_err_ff    <= o_err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // register readback
   always_comb begin
      if (csr_paddr[2] == REG_COMPONENTS) begin
         csr_prdata = 32'(comps_ff);
      end else begin
         csr_prdata = 32'(pieces_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `EMJS_ASSERT_IMP(a_clear_blocks_req, state_ff == S_CLEAR, !req_tready, "request taken during table clear")
   `EMJS_ASSERT_NXT(a_accept_starts_work, accept, state_ff != S_IDLE, "accepted transaction not started")
   `EMJS_ASSERT_IMP(a_div_done_awaited, div_rsp.done, state_ff == S_LAP_DIVW || state_ff == S_FIN_DIVW, "divider finished unexpectedly")
   `EMJS_ASSERT_IMP(a_zero_uniform_sat, rsp_tvalid && rsp_tuser == ERR_ZERO_UNIFORM, rsp_tdata[31:0] == MAX32, "zero uniform not saturated")

endmodule
